[sv/assert_macros.svh]
// Assertion macros for the RTL of the boiler heater controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/bmhc_pkg.sv]
// Package for the boiler heater controller: mode and fault codes, button
// geometry, register indexes, reset fractions and the result word type.
// No dependencies.
package bmhc_pkg;

  localparam int unsigned SAMPLE_BITS_DEFAULT = 12;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOT_STAGE1   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOT_STAGE2   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEAM_STAGE1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEAM_STAGE2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERHEAT     = 3'd4;

  // reset limits in tenths of full scale
  localparam int unsigned TENTHS_HOT_STAGE1   = 5;
  localparam int unsigned TENTHS_HOT_STAGE2   = 3;
  localparam int unsigned TENTHS_STEAM_STAGE1 = 7;
  localparam int unsigned TENTHS_STEAM_STAGE2 = 5;
  localparam int unsigned TENTHS_OVERHEAT     = 9;

  localparam int unsigned X_BITS = 8;
  localparam int unsigned Y_BITS = 9;

  typedef enum logic [2:0] {
    MODE_STARTUP = 3'd0,
    MODE_LOW     = 3'd1,
    MODE_HOT     = 3'd2,
    MODE_STEAM   = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_HOT     = 2'd1,
    CAUSE_INVALID = 2'd2
  } cause_t;

  typedef struct packed {
    mode_t  mode;
    logic   changed;
    logic   stage1;
    logic   stage2;
    cause_t cause;
  } result_t;

  // strict bounds on every edge
  function automatic logic in_box(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y,
                                  input logic [X_BITS-1:0] x_lo, input logic [X_BITS-1:0] x_hi,
                                  input logic [Y_BITS-1:0] y_lo, input logic [Y_BITS-1:0] y_hi);
    return (x > x_lo) && (x < x_hi) && (y > y_lo) && (y < y_hi);
  endfunction

  function automatic logic on_button(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
    return in_box(x, y, 8'd50, 8'd150, 9'd100, 9'd150);
  endfunction

  function automatic logic off_button(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
    return in_box(x, y, 8'd50, 8'd150, 9'd70, 9'd120);
  endfunction

  function automatic logic mode_button(input logic [X_BITS-1:0] x, input logic [Y_BITS-1:0] y);
    return in_box(x, y, 8'd50, 8'd200, 9'd140, 9'd190);
  endfunction

endpackage

[sv/boiler_mode_heater_controller_unit.sv]
// Top level of the boiler mode and heater controller.
// Depends on bmhc_pkg, bmhc_cfg_regs, bmhc_mode_fsm and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one word per tick, a temperature
// sample plus a touch report (touch_detected, touch_x, touch_y).
// Output channel (out_valid / out_stall): one result word per input word:
// mode, mode_changed, heater_stage1, heater_stage2, fault_reason.
// Config port: cfg_we writes cfg_data to threshold cfg_index (0..4) at the
// clock edge; unknown indexes are dropped. Write only while idle.
// The result word passes through the input register, then the result register.
// Throughput: one word per cycle while out_stall is low, bounded by the
// single mode/heater update between the two registers.
// Reset (rst, synchronous): mode startup, heaters off, no fault, thresholds
// to their defaults, both pipeline registers empty.
// Stall: while out_stall holds, the result word stays put; the input
// register still takes one more word, then in_stall rises until the
// result is taken.
`include "assert_macros.svh"

module boiler_mode_heater_controller_unit #(
  parameter int unsigned SAMPLE_BITS = bmhc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              temp_sample,
  input  logic                                touch_detected,
  input  logic [bmhc_pkg::X_BITS-1:0]         touch_x,
  input  logic [bmhc_pkg::Y_BITS-1:0]         touch_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          mode,
  output logic                                mode_changed,
  output logic                                heater_stage1,
  output logic                                heater_stage2,
  output logic [1:0]                          fault_reason,
  input  logic                                cfg_we,
  input  logic [bmhc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data
);

  logic [SAMPLE_BITS-1:0] hot_stage1_limit, hot_stage2_limit;
  logic [SAMPLE_BITS-1:0] steam_stage1_limit, steam_stage2_limit, overheat_limit;

  logic                        in_full;
  logic [SAMPLE_BITS-1:0]      in_temp;
  logic                        in_touch;
  logic [bmhc_pkg::X_BITS-1:0] in_x;
  logic [bmhc_pkg::Y_BITS-1:0] in_y;

  logic              advance, accept;
  bmhc_pkg::result_t result, out_word;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_temp  <= temp_sample;
      in_touch <= touch_detected;
      in_x     <= touch_x;
      in_y     <= touch_y;
    end
  end

  bmhc_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .hot_stage1_limit   (hot_stage1_limit),
    .hot_stage2_limit   (hot_stage2_limit),
    .steam_stage1_limit (steam_stage1_limit),
    .steam_stage2_limit (steam_stage2_limit),
    .overheat_limit     (overheat_limit)
  );

  bmhc_mode_fsm #(.SAMPLE_BITS(SAMPLE_BITS)) u_fsm (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .temp_sample        (in_temp),
    .touch_detected     (in_touch),
    .touch_x            (in_x),
    .touch_y            (in_y),
    .hot_stage1_limit   (hot_stage1_limit),
    .hot_stage2_limit   (hot_stage2_limit),
    .steam_stage1_limit (steam_stage1_limit),
    .steam_stage2_limit (steam_stage2_limit),
    .overheat_limit     (overheat_limit),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign mode          = out_word.mode;
  assign mode_changed  = out_word.changed;
  assign heater_stage1 = out_word.stage1;
  assign heater_stage2 = out_word.stage2;
  assign fault_reason  = out_word.cause;

  `ASSERT_ALWAYS(a_fault_heaters_off, clk, rst, (out_valid && out_word.mode == bmhc_pkg::MODE_FAULT) |-> (!out_word.stage1 && !out_word.stage2), "heater on in fault mode")
  `ASSERT_ALWAYS(a_cause_needs_fault, clk, rst, (out_valid && out_word.cause != bmhc_pkg::CAUSE_NONE) |-> (out_word.mode == bmhc_pkg::MODE_FAULT), "fault reason without fault mode")
  `ASSERT_NEVER(a_stage2_alone, clk, rst, out_valid && out_word.stage2 && !out_word.stage1, "stage two on without stage one")
  `ASSERT_ALWAYS(a_stall_only_full, clk, rst, in_stall |-> (in_full && out_valid && out_stall), "input stalled with room")

endmodule

[sv/bmhc_cfg_regs.sv]
// Threshold register file of the boiler heater controller.
// Depends on bmhc_pkg.
module bmhc_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = bmhc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bmhc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  output logic [SAMPLE_BITS-1:0]              hot_stage1_limit,
  output logic [SAMPLE_BITS-1:0]              hot_stage2_limit,
  output logic [SAMPLE_BITS-1:0]              steam_stage1_limit,
  output logic [SAMPLE_BITS-1:0]              steam_stage2_limit,
  output logic [SAMPLE_BITS-1:0]              overheat_limit
);

  localparam logic [63:0] FULL = 64'd1 << SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] HOT1_RST =
    SAMPLE_BITS'((FULL * bmhc_pkg::TENTHS_HOT_STAGE1 + 64'd5) / 64'd10);
  localparam logic [SAMPLE_BITS-1:0] HOT2_RST =
    SAMPLE_BITS'((FULL * bmhc_pkg::TENTHS_HOT_STAGE2 + 64'd5) / 64'd10);
  localparam logic [SAMPLE_BITS-1:0] STEAM1_RST =
    SAMPLE_BITS'((FULL * bmhc_pkg::TENTHS_STEAM_STAGE1 + 64'd5) / 64'd10);
  localparam logic [SAMPLE_BITS-1:0] STEAM2_RST =
    SAMPLE_BITS'((FULL * bmhc_pkg::TENTHS_STEAM_STAGE2 + 64'd5) / 64'd10);
  localparam logic [SAMPLE_BITS-1:0] OVER_RST =
    SAMPLE_BITS'((FULL * bmhc_pkg::TENTHS_OVERHEAT + 64'd5) / 64'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_stage1_limit   <= HOT1_RST;
      hot_stage2_limit   <= HOT2_RST;
      steam_stage1_limit <= STEAM1_RST;
      steam_stage2_limit <= STEAM2_RST;
      overheat_limit     <= OVER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmhc_pkg::CFG_HOT_STAGE1:   hot_stage1_limit   <= cfg_data;
        bmhc_pkg::CFG_HOT_STAGE2:   hot_stage2_limit   <= cfg_data;
        bmhc_pkg::CFG_STEAM_STAGE1: steam_stage1_limit <= cfg_data;
        bmhc_pkg::CFG_STEAM_STAGE2: steam_stage2_limit <= cfg_data;
        bmhc_pkg::CFG_OVERHEAT:     overheat_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/bmhc_mode_fsm.sv]
// Mode state machine and heater drive of the boiler heater controller.
// Depends on bmhc_pkg.
module bmhc_mode_fsm #(
  parameter int unsigned SAMPLE_BITS = bmhc_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [SAMPLE_BITS-1:0]      temp_sample,
  input  logic                        touch_detected,
  input  logic [bmhc_pkg::X_BITS-1:0] touch_x,
  input  logic [bmhc_pkg::Y_BITS-1:0] touch_y,
  input  logic [SAMPLE_BITS-1:0]      hot_stage1_limit,
  input  logic [SAMPLE_BITS-1:0]      hot_stage2_limit,
  input  logic [SAMPLE_BITS-1:0]      steam_stage1_limit,
  input  logic [SAMPLE_BITS-1:0]      steam_stage2_limit,
  input  logic [SAMPLE_BITS-1:0]      overheat_limit,
  output bmhc_pkg::result_t           result
);

  bmhc_pkg::mode_t  mode, mode_next;
  bmhc_pkg::cause_t cause, cause_next;
  logic             stage1, stage1_next;
  logic             stage2, stage2_next;

  logic                   hit_on, hit_off, hit_mode;
  logic [SAMPLE_BITS-1:0] lim1, lim2;
  logic                   below1, below2, below_over;

  assign hit_on   = touch_detected && bmhc_pkg::on_button(touch_x, touch_y);
  assign hit_off  = touch_detected && bmhc_pkg::off_button(touch_x, touch_y);
  assign hit_mode = touch_detected && bmhc_pkg::mode_button(touch_x, touch_y);

  assign lim1 = (mode == bmhc_pkg::MODE_STEAM) ? steam_stage1_limit : hot_stage1_limit;
  assign lim2 = (mode == bmhc_pkg::MODE_STEAM) ? steam_stage2_limit : hot_stage2_limit;

  assign below1     = temp_sample < lim1;
  assign below2     = temp_sample < lim2;
  assign below_over = temp_sample < overheat_limit;

  always_comb begin
    mode_next = mode;
    unique case (mode)
      bmhc_pkg::MODE_STARTUP: mode_next = bmhc_pkg::MODE_LOW;
      bmhc_pkg::MODE_LOW: begin
        if (hit_on) mode_next = bmhc_pkg::MODE_HOT;
      end
      bmhc_pkg::MODE_HOT, bmhc_pkg::MODE_STEAM: begin
        priority if (hit_off) mode_next = bmhc_pkg::MODE_LOW;
        else if (hit_mode) begin
          mode_next = (mode == bmhc_pkg::MODE_HOT) ? bmhc_pkg::MODE_STEAM
                                                   : bmhc_pkg::MODE_HOT;
        end else if (!below1 && !below_over) mode_next = bmhc_pkg::MODE_FAULT;
        else mode_next = mode;
      end
      bmhc_pkg::MODE_FAULT: mode_next = bmhc_pkg::MODE_FAULT;
      default: mode_next = bmhc_pkg::MODE_FAULT;
    endcase
  end

  always_comb begin
    stage1_next = stage1;
    stage2_next = stage2;
    cause_next  = cause;
    unique case (mode)
      bmhc_pkg::MODE_STARTUP, bmhc_pkg::MODE_LOW: ;
      bmhc_pkg::MODE_HOT, bmhc_pkg::MODE_STEAM: begin
        priority if (hit_off) begin
          stage1_next = 1'b0;
          stage2_next = 1'b0;
        end else if (hit_mode) begin
          stage1_next = stage1;
        end else if (below1) begin
          stage1_next = 1'b1;
          stage2_next = below2;
        end else begin
          stage1_next = 1'b0;
          stage2_next = 1'b0;
          if (!below_over) cause_next = bmhc_pkg::CAUSE_HOT;
        end
      end
      bmhc_pkg::MODE_FAULT: begin
        stage1_next = 1'b0;
        stage2_next = 1'b0;
      end
      default: begin
        stage1_next = 1'b0;
        stage2_next = 1'b0;
        cause_next  = bmhc_pkg::CAUSE_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= bmhc_pkg::MODE_STARTUP;
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      cause  <= bmhc_pkg::CAUSE_NONE;
    end else if (advance) begin
      mode   <= mode_next;
      stage1 <= stage1_next;
      stage2 <= stage2_next;
      cause  <= cause_next;
    end
  end

  always_comb begin
    result.mode    = mode_next;
    result.changed = (mode_next != mode);
    result.stage1  = stage1_next;
    result.stage2  = stage2_next;
    result.cause   = cause_next;
  end

endmodule

[test/tb_boiler_mode_heater_controller_unit.sv]
`timescale 1ns / 100ps
// Bench for boiler_mode_heater_controller_unit: directed and random tick words,
// a tracking model of mode, heaters and fault, and threshold rewrites between phases.
// Depends on bmhc_pkg and the controller RTL.

module tb_boiler_mode_heater_controller_unit;

  localparam int SW = bmhc_pkg::SAMPLE_BITS_DEFAULT;
  localparam int XB = bmhc_pkg::X_BITS;
  localparam int YB = bmhc_pkg::Y_BITS;
  localparam int LIMIT_MAX = (1 << SW) - 1;
  localparam int X_MAX = 239;
  localparam int Y_MAX = 319;
  localparam int BTN_X_LO = 50;
  localparam int BTN_X_HI = 150;
  localparam int MODE_X_HI = 200;
  localparam int ON_Y_LO = 100;
  localparam int ON_Y_HI = 150;
  localparam int OFF_Y_LO = 70;
  localparam int OFF_Y_HI = 120;
  localparam int MODE_Y_LO = 140;
  localparam int MODE_Y_HI = 190;
  localparam logic [bmhc_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SW-1:0] temp;
    logic          touch;
    logic [XB-1:0] x;
    logic [YB-1:0] y;
  } tick_t;

  typedef struct packed {
    bmhc_pkg::mode_t  mode;
    logic             s1;
    logic             s2;
    bmhc_pkg::cause_t cause;
  } plant_t;

  class heater_tracker;
    logic [SW-1:0] limit [5];
    plant_t now;
    bmhc_pkg::result_t due_results [$];
    int mismatches;
    int checked;
    int mode_hits [5];

    static function logic [SW-1:0] tenths(input int unsigned k);
      return SW'(((longint'(1) << SW) * k + 5) / 10);
    endfunction

    static function bit on_target(input int x, input int y, input int xlo, input int xhi,
                                  input int ylo, input int yhi);
      return x > xlo && x < xhi && y > ylo && y < yhi;
    endfunction

    function new();
      limit[bmhc_pkg::CFG_HOT_STAGE1]   = tenths(bmhc_pkg::TENTHS_HOT_STAGE1);
      limit[bmhc_pkg::CFG_HOT_STAGE2]   = tenths(bmhc_pkg::TENTHS_HOT_STAGE2);
      limit[bmhc_pkg::CFG_STEAM_STAGE1] = tenths(bmhc_pkg::TENTHS_STEAM_STAGE1);
      limit[bmhc_pkg::CFG_STEAM_STAGE2] = tenths(bmhc_pkg::TENTHS_STEAM_STAGE2);
      limit[bmhc_pkg::CFG_OVERHEAT]     = tenths(bmhc_pkg::TENTHS_OVERHEAT);
      now = '{bmhc_pkg::MODE_STARTUP, 1'b0, 1'b0, bmhc_pkg::CAUSE_NONE};
    endfunction

    function void set_limit(input logic [bmhc_pkg::CFG_INDEX_BITS-1:0] idx,
                            input logic [SW-1:0] v);
      if (idx <= bmhc_pkg::CFG_OVERHEAT) limit[idx] = v;
    endfunction

    // lowest sample that would latch an overheat in the current heating mode
    function int fault_threshold();
      int lim1;
      int over;
      lim1 = (now.mode == bmhc_pkg::MODE_HOT) ? int'(limit[bmhc_pkg::CFG_HOT_STAGE1])
                                              : int'(limit[bmhc_pkg::CFG_STEAM_STAGE1]);
      over = int'(limit[bmhc_pkg::CFG_OVERHEAT]);
      return (lim1 > over) ? lim1 : over;
    endfunction

    function bmhc_pkg::result_t advance(inout plant_t st, input tick_t w);
      bmhc_pkg::mode_t prior;
      logic [SW-1:0] lim1;
      logic [SW-1:0] lim2;
      bmhc_pkg::result_t r;
      prior = st.mode;
      lim1 = (st.mode == bmhc_pkg::MODE_HOT) ? limit[bmhc_pkg::CFG_HOT_STAGE1]
                                             : limit[bmhc_pkg::CFG_STEAM_STAGE1];
      lim2 = (st.mode == bmhc_pkg::MODE_HOT) ? limit[bmhc_pkg::CFG_HOT_STAGE2]
                                             : limit[bmhc_pkg::CFG_STEAM_STAGE2];
      case (st.mode)
        bmhc_pkg::MODE_STARTUP: st.mode = bmhc_pkg::MODE_LOW;
        bmhc_pkg::MODE_LOW: begin
          if (w.touch && on_target(int'(w.x), int'(w.y), BTN_X_LO, BTN_X_HI, ON_Y_LO, ON_Y_HI))
            st.mode = bmhc_pkg::MODE_HOT;
        end
        bmhc_pkg::MODE_HOT, bmhc_pkg::MODE_STEAM: begin
          if (w.touch &&
              on_target(int'(w.x), int'(w.y), BTN_X_LO, BTN_X_HI, OFF_Y_LO, OFF_Y_HI)) begin
            st.s1 = 1'b0;
            st.s2 = 1'b0;
            st.mode = bmhc_pkg::MODE_LOW;
          end else if (w.touch &&
                       on_target(int'(w.x), int'(w.y), BTN_X_LO, MODE_X_HI,
                                 MODE_Y_LO, MODE_Y_HI)) begin
            if (st.mode == bmhc_pkg::MODE_HOT) st.mode = bmhc_pkg::MODE_STEAM;
            else st.mode = bmhc_pkg::MODE_HOT;
          end else if (w.temp < lim1) begin
            st.s1 = 1'b1;
            st.s2 = w.temp < lim2;
          end else if (w.temp < limit[bmhc_pkg::CFG_OVERHEAT]) begin
            st.s1 = 1'b0;
            st.s2 = 1'b0;
          end else begin
            st = '{bmhc_pkg::MODE_FAULT, 1'b0, 1'b0, bmhc_pkg::CAUSE_HOT};
          end
        end
        bmhc_pkg::MODE_FAULT: begin
          st.s1 = 1'b0;
          st.s2 = 1'b0;
        end
        default: st = '{bmhc_pkg::MODE_FAULT, 1'b0, 1'b0, bmhc_pkg::CAUSE_INVALID};
      endcase
      r.mode = st.mode;
      r.changed = st.mode != prior;
      r.stage1 = st.s1;
      r.stage2 = st.s2;
      r.cause = st.cause;
      return r;
    endfunction

    function bmhc_pkg::result_t preview(input tick_t w);
      plant_t probe;
      probe = now;
      return advance(probe, w);
    endfunction

    function void note_tick(input tick_t w);
      due_results.push_back(advance(now, w));
    endfunction

    task flag_mismatch(input string what, input logic [2:0] got, input logic [2:0] want);
      $display("%0t: word %0d, %s: got %0d, expected %0d", $time, checked, what, got, want);
      mismatches++;
    endtask

    task check_result(input bmhc_pkg::result_t got);
      bmhc_pkg::result_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("word with nothing pending", got.mode, 'x);
        return;
      end
      want = due_results.pop_front();
      checked++;
      mode_hits[want.mode]++;
      if (got.mode !== want.mode) flag_mismatch("mode", got.mode, want.mode);
      if (got.changed !== want.changed)
        flag_mismatch("mode_changed", 3'(got.changed), 3'(want.changed));
      if (got.stage1 !== want.stage1)
        flag_mismatch("heater_stage1", 3'(got.stage1), 3'(want.stage1));
      if (got.stage2 !== want.stage2)
        flag_mismatch("heater_stage2", 3'(got.stage2), 3'(want.stage2));
      if (got.cause !== want.cause)
        flag_mismatch("fault_reason", 3'(got.cause), 3'(want.cause));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SW-1:0] temp_sample = '0;
  logic touch_detected = 1'b0;
  logic [XB-1:0] touch_x = '0;
  logic [YB-1:0] touch_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] mode;
  logic mode_changed;
  logic heater_stage1;
  logic heater_stage2;
  logic [1:0] fault_reason;
  logic cfg_we = 1'b0;
  logic [bmhc_pkg::CFG_INDEX_BITS-1:0] cfg_index = bmhc_pkg::CFG_HOT_STAGE1;
  logic [SW-1:0] cfg_data = '0;

  int tx_idle_pct = 12;
  int rx_idle_pct = 80;
  int rx_hold = 0;
  int limit_settings = 1;
  heater_tracker sb;

  boiler_mode_heater_controller_unit #(.SAMPLE_BITS(SW)) u_top (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= $urandom_range(99) < rx_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(bmhc_pkg::result_t'{bmhc_pkg::mode_t'(mode), mode_changed,
                                          heater_stage1, heater_stage2,
                                          bmhc_pkg::cause_t'(fault_reason)});
  end

  task automatic offer(input tick_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    temp_sample <= w.temp;
    touch_detected <= w.touch;
    touch_x <= w.x;
    touch_y <= w.y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(w);
  endtask

  task automatic offer_at(input int t, input bit pressed, input int x, input int y);
    offer(tick_t'{t[SW-1:0], pressed, x[XB-1:0], y[YB-1:0]});
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_limits(input int h1, input int h2, input int s1, input int s2,
                                input int oh);
    logic [SW-1:0] vals [5];
    vals = '{SW'(h1), SW'(h2), SW'(s1), SW'(s2), SW'(oh)};
    for (int i = int'(bmhc_pkg::CFG_HOT_STAGE1); i <= int'(bmhc_pkg::CFG_OVERHEAT); i++) begin
      cfg_we <= 1'b1;
      cfg_index <= bmhc_pkg::CFG_INDEX_BITS'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_limit(bmhc_pkg::CFG_INDEX_BITS'(i), vals[i]);
    end
    // unmapped index, dropped by the block
    cfg_index <= CFG_UNUSED;
    cfg_data <= SW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  function automatic logic [SW-1:0] random_temp();
    int pick;
    int base;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    if (pick < 45) begin
      base = int'(sb.limit[$urandom_range(bmhc_pkg::CFG_OVERHEAT)]) +
             int'($urandom_range(2)) - 1;
      if (base < 0) base = 0;
      if (base > LIMIT_MAX) base = LIMIT_MAX;
      return base[SW-1:0];
    end
    return SW'($urandom_range(LIMIT_MAX));
  endfunction

  function automatic void aim(inout tick_t w, input int xhi, input int ylo, input int yhi);
    w.touch = 1'b1;
    w.x = XB'($urandom_range(xhi, BTN_X_LO));
    w.y = YB'($urandom_range(yhi, ylo));
  endfunction

  function automatic tick_t random_tick(input bit allow_fault);
    tick_t w;
    bmhc_pkg::result_t probe;
    int pick;
    int ceiling;
    w.temp = random_temp();
    w.touch = 1'b0;
    w.x = XB'($urandom_range(X_MAX));
    w.y = YB'($urandom_range(Y_MAX));
    pick = $urandom_range(99);
    case (sb.now.mode)
      bmhc_pkg::MODE_LOW: begin
        if (pick < 40) aim(w, BTN_X_HI, ON_Y_LO, ON_Y_HI);
        else w.touch = pick < 70;
      end
      bmhc_pkg::MODE_HOT, bmhc_pkg::MODE_STEAM: begin
        if (pick < 6) aim(w, BTN_X_HI, OFF_Y_LO, OFF_Y_HI);
        else if (pick < 16) aim(w, MODE_X_HI, MODE_Y_LO, MODE_Y_HI);
        else w.touch = pick < 35;
      end
      default: w.touch = pick < 50;
    endcase
    // fault is sticky until reset, so keep it for the last phase
    probe = sb.preview(w);
    if (!allow_fault && probe.mode == bmhc_pkg::MODE_FAULT) begin
      ceiling = sb.fault_threshold();
      if (ceiling > 0) w.temp = SW'($urandom_range(ceiling - 1));
      else aim(w, BTN_X_HI, OFF_Y_LO, OFF_Y_HI);
    end
    return w;
  endfunction

  task automatic run_phase(input int words, input bit allow_fault);
    for (int i = 0; i < words; i++) begin
      if (i == 120) rx_hold = 30 + $urandom_range(30);
      if (i == 200) wait_for_results();
      offer(random_tick(allow_fault));
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    offer_at(LIMIT_MAX, 1'b1, 100, 125);
    offer_at(0, 1'b0, 0, 0);
    offer_at(0, 1'b0, 100, 125);
    offer_at(0, 1'b1, BTN_X_LO, 125);
    offer_at(0, 1'b1, BTN_X_HI, 125);
    offer_at(0, 1'b1, 100, ON_Y_LO);
    offer_at(0, 1'b1, 100, ON_Y_HI);
    offer_at(0, 1'b1, BTN_X_LO + 1, ON_Y_LO + 1);
    offer_at(0, 1'b0, X_MAX, Y_MAX);
    offer_at(sb.limit[bmhc_pkg::CFG_HOT_STAGE2] - 1, 1'b0, 0, 0);
    offer_at(sb.limit[bmhc_pkg::CFG_HOT_STAGE2], 1'b1, X_MAX, Y_MAX);
    offer_at(sb.limit[bmhc_pkg::CFG_HOT_STAGE1] - 1, 1'b0, 0, 0);
    offer_at(sb.limit[bmhc_pkg::CFG_HOT_STAGE1], 1'b0, 0, 0);
    offer_at(sb.limit[bmhc_pkg::CFG_OVERHEAT] - 1, 1'b0, 0, 0);
    offer_at(0, 1'b0, 0, 0);
    // mode button holds the heaters even at full-scale temperature
    offer_at(LIMIT_MAX, 1'b1, MODE_X_HI - 1, MODE_Y_HI - 1);
    offer_at(sb.limit[bmhc_pkg::CFG_STEAM_STAGE2], 1'b0, 0, 0);
    offer_at(sb.limit[bmhc_pkg::CFG_STEAM_STAGE1], 1'b0, 0, 0);
    offer_at(0, 1'b0, 0, 0);
    offer_at(LIMIT_MAX, 1'b1, BTN_X_HI - 1, OFF_Y_HI - 1);
    offer_at(0, 1'b1, BTN_X_HI - 1, ON_Y_HI - 1);
    offer_at(LIMIT_MAX, 1'b1, BTN_X_LO + 1, MODE_Y_LO + 1);
    offer_at(0, 1'b1, MODE_X_HI, 165);
    offer_at(0, 1'b1, 100, 165);
    offer_at(LIMIT_MAX, 1'b1, 100, 110);
    run_phase(300, 1'b0);

    wait_for_results();
    program_limits($urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX));
    run_phase(300, 1'b0);

    tx_idle_pct = 80;
    rx_idle_pct = 12;
    wait_for_results();
    program_limits(0, LIMIT_MAX, LIMIT_MAX, 0, LIMIT_MAX);
    run_phase(300, 1'b0);
    wait_for_results();
    program_limits($urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX));
    run_phase(300, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_for_results();
    program_limits($urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX), $urandom_range(LIMIT_MAX),
                   $urandom_range(LIMIT_MAX));
    run_phase(300, 1'b0);
    wait_for_results();
    program_limits(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    run_phase(300, 1'b0);

    // heaters on in hot water, then zero limits force the overheat latch
    while (sb.now.mode != bmhc_pkg::MODE_HOT) begin
      if (sb.now.mode == bmhc_pkg::MODE_LOW) offer_at(0, 1'b1, 100, 125);
      else offer_at(0, 1'b1, 100, 165);
    end
    offer_at(0, 1'b0, 0, 0);
    wait_for_results();
    program_limits(0, 0, 0, 0, 0);
    offer_at(0, 1'b0, 0, 0);
    run_phase(100, 1'b1);
    wait_for_results();

    $display("Checked %0d result words over %0d threshold settings, zero and full scale included.",
             sb.checked, limit_settings);
    $display("Words per mode: startup %0d, low power %0d, hot water %0d, steam %0d, fault %0d",
             sb.mode_hits[bmhc_pkg::MODE_STARTUP], sb.mode_hits[bmhc_pkg::MODE_LOW],
             sb.mode_hits[bmhc_pkg::MODE_HOT], sb.mode_hits[bmhc_pkg::MODE_STEAM],
             sb.mode_hits[bmhc_pkg::MODE_FAULT]);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
